[rtl/thi_pwm_pkg.sv]
// Shared types, constants, sine table and helpers for the third-harmonic PWM generator.
package thi_pwm_pkg;

	// Field widths
	localparam int PERIOD_W   = 16;
	localparam int STEP_W     = 16;
	localparam int SCALE_W    = 24;
	localparam int GAIN_W     = 24;
	localparam int FREQ_W     = 24;
	localparam int CMP_W      = 16;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;

	// Sine table and phase
	localparam int SINE_TABLE_BITS = 10;
	localparam int PHASE_BITS      = 32;
	localparam int QUARTER         = 2 ** (SINE_TABLE_BITS - 2);
	localparam int QIDX_W          = SINE_TABLE_BITS - 1;
	localparam int SINE_MAG_W      = 17;
	localparam int SINE_W          = 18;
	localparam logic [PHASE_BITS-1:0] PHASE_OFFSET =
		PHASE_BITS'(((64'd1 << PHASE_BITS) + 64'd1) / 64'd3);

	// Datapath arithmetic
	localparam int MUL_A_W    = 26;
	localparam int MUL_B_W    = 25;
	localparam int PROD_W     = 51;
	localparam int AMP_W      = 25;
	localparam int AMP_SHIFT  = 23;
	localparam int W6_W       = 20;
	localparam int NUM_SPLIT  = 22;
	localparam int NUM_HI_W   = 22;
	localparam int LO_PROD_W  = 38;
	localparam int P_W        = 60;
	localparam int Q_SHIFT    = 34;
	localparam int Y_W        = 26;
	localparam int YQ_W       = 19;
	localparam int RECIP_W    = 20;
	localparam int RECIP_SHIFT = 20;
	localparam int INC_SHIFT  = 16;
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);
	localparam logic signed [PROD_W-1:0] NUM_BIAS = PROD_W'(64'd6 << 32);
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
	localparam logic [63:0] Q30_ONE    = 64'd1 << 30;

	// Register defaults
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1875;
	localparam logic [STEP_W-1:0]   STEP_RST   = 16'd16;
	localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd429497;
	localparam logic [GAIN_W-1:0]   GAIN_RST   = 24'd193725;

	// Lane codes
	localparam logic [1:0] LANE_LAST_SINE = 2'd3;
	localparam logic [1:0] LANE_LAST_CMP  = 2'd2;
	localparam logic [1:0] LANE_THIRD     = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PWM_PERIOD,
		REG_RAMP_STEP,
		REG_PHASE_SCALE,
		REG_AMPLITUDE_GAIN
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_AMP, ST_SINE, ST_WEIGHT, ST_SPLIT, ST_HIGH,
		ST_QUOT, ST_RECIP, ST_STORE, ST_INCR, ST_ADV, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_AMP, OP_SINE, OP_WEIGHT, OP_SPLIT, OP_HIGH,
		OP_QUOT, OP_RECIP, OP_STORE, OP_INCR, OP_ADV, OP_DONE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] lane;
	} cmd_t;

	typedef struct packed {
		logic [CMP_W-1:0]  compare_a;
		logic [CMP_W-1:0]  compare_b;
		logic [CMP_W-1:0]  compare_c;
		logic              enable_pin;
		logic              enable_inverted_pin;
		logic              fault_reset_pin;
		logic [FREQ_W-1:0] present_frequency;
	} result_t;

	typedef logic [SINE_MAG_W-1:0] sine_lut_t [QUARTER+1];

	// Quarter-wave sine in Q16, Taylor series in Q30 evaluated at elaboration
	function automatic sine_lut_t build_sine_lut();
		sine_lut_t  lut;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		for (int q = 0; q <= QUARTER; q++) begin
			x  = (64'(q) * TWO_PI_Q30) >> SINE_TABLE_BITS;
			x2 = (x * x) >> 30;
			t  = Q30_ONE;
			t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
			t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
			t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
			t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
			t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
			lut[q] = SINE_MAG_W'((((x * t) >> 30) + 64'd8192) >> 14);
		end
		return lut;
	endfunction

	localparam sine_lut_t SINE_LUT = build_sine_lut();

	// Signed Q16 sine of a phase, quadrants folded onto the quarter table
	function automatic logic signed [SINE_W-1:0] sine_of(input logic [PHASE_BITS-1:0] phase);
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [QIDX_W-1:0]          r;
		logic [QIDX_W-1:0]          q;
		logic signed [SINE_W-1:0]   mag;
		idx = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
		r   = {1'b0, idx[SINE_TABLE_BITS-3:0]};
		q   = idx[SINE_TABLE_BITS-2] ? QIDX_W'(QUARTER) - r : r;
		mag = $signed({1'b0, SINE_LUT[q]});
		return idx[SINE_TABLE_BITS-1] ? -mag : mag;
	endfunction

endpackage

[rtl/thi_pwm_if.sv]
// Request channel interfaces: PWM tick in, compare result out.
interface thi_pwm_tick_if;
	logic                            valid;
	logic                            ready;
	logic [thi_pwm_pkg::FREQ_W-1:0]  target_frequency;
	logic                            enable_request;
	logic                            fault_reset_request;

	modport source (output valid, target_frequency, enable_request, fault_reset_request,
		input ready);
	modport sink (input valid, target_frequency, enable_request, fault_reset_request,
		output ready);
endinterface

interface thi_pwm_result_if;
	logic                            valid;
	logic                            ready;
	logic [thi_pwm_pkg::CMP_W-1:0]   compare_a;
	logic [thi_pwm_pkg::CMP_W-1:0]   compare_b;
	logic [thi_pwm_pkg::CMP_W-1:0]   compare_c;
	logic                            enable_pin;
	logic                            enable_inverted_pin;
	logic                            fault_reset_pin;
	logic [thi_pwm_pkg::FREQ_W-1:0]  present_frequency;

	modport source (output valid, compare_a, compare_b, compare_c, enable_pin,
		enable_inverted_pin, fault_reset_pin, present_frequency, input ready);
	modport sink (input valid, compare_a, compare_b, compare_c, enable_pin,
		enable_inverted_pin, fault_reset_pin, present_frequency, output ready);
endinterface

[rtl/thi_pwm_ctrl.sv]
// Sequencer: walks one tick through the shared-multiplier datapath.
module thi_pwm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output thi_pwm_pkg::cmd_t   cmd
);

	thi_pwm_pkg::state_t state_q;
	thi_pwm_pkg::state_t state_nx;
	logic [1:0]          lane_q;
	logic                out_valid_q;
	logic                out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			thi_pwm_pkg::ST_IDLE:   if (in_valid) state_nx = thi_pwm_pkg::ST_AMP;
			thi_pwm_pkg::ST_AMP:    state_nx = thi_pwm_pkg::ST_SINE;
			thi_pwm_pkg::ST_SINE:   if (lane_q == thi_pwm_pkg::LANE_LAST_SINE)
				state_nx = thi_pwm_pkg::ST_WEIGHT;
			thi_pwm_pkg::ST_WEIGHT: state_nx = thi_pwm_pkg::ST_SPLIT;
			thi_pwm_pkg::ST_SPLIT:  state_nx = thi_pwm_pkg::ST_HIGH;
			thi_pwm_pkg::ST_HIGH:   state_nx = thi_pwm_pkg::ST_QUOT;
			thi_pwm_pkg::ST_QUOT:   state_nx = thi_pwm_pkg::ST_RECIP;
			thi_pwm_pkg::ST_RECIP:  state_nx = thi_pwm_pkg::ST_STORE;
			thi_pwm_pkg::ST_STORE:  state_nx = (lane_q == thi_pwm_pkg::LANE_LAST_CMP) ?
				thi_pwm_pkg::ST_INCR : thi_pwm_pkg::ST_WEIGHT;
			thi_pwm_pkg::ST_INCR:   state_nx = thi_pwm_pkg::ST_ADV;
			thi_pwm_pkg::ST_ADV:    state_nx = thi_pwm_pkg::ST_DONE;
			thi_pwm_pkg::ST_DONE:   if (out_free) state_nx = thi_pwm_pkg::ST_IDLE;
			default:                state_nx = thi_pwm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.lane = lane_q;
		cmd.op   = thi_pwm_pkg::OP_NONE;
		unique case (state_q)
			thi_pwm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = thi_pwm_pkg::OP_LOAD;
			end
			thi_pwm_pkg::ST_AMP:    cmd.op = thi_pwm_pkg::OP_AMP;
			thi_pwm_pkg::ST_SINE:   cmd.op = thi_pwm_pkg::OP_SINE;
			thi_pwm_pkg::ST_WEIGHT: cmd.op = thi_pwm_pkg::OP_WEIGHT;
			thi_pwm_pkg::ST_SPLIT:  cmd.op = thi_pwm_pkg::OP_SPLIT;
			thi_pwm_pkg::ST_HIGH:   cmd.op = thi_pwm_pkg::OP_HIGH;
			thi_pwm_pkg::ST_QUOT:   cmd.op = thi_pwm_pkg::OP_QUOT;
			thi_pwm_pkg::ST_RECIP:  cmd.op = thi_pwm_pkg::OP_RECIP;
			thi_pwm_pkg::ST_STORE:  cmd.op = thi_pwm_pkg::OP_STORE;
			thi_pwm_pkg::ST_INCR:   cmd.op = thi_pwm_pkg::OP_INCR;
			thi_pwm_pkg::ST_ADV:    cmd.op = thi_pwm_pkg::OP_ADV;
			thi_pwm_pkg::ST_DONE:   if (out_free) cmd.op = thi_pwm_pkg::OP_DONE;
			default:                cmd.op = thi_pwm_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= thi_pwm_pkg::ST_IDLE;
			lane_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			// lane wraps from 3 to 0 at the end of the sine sweep
			if (state_q == thi_pwm_pkg::ST_SINE) begin
				lane_q <= lane_q + 2'd1;
			end else if (state_q == thi_pwm_pkg::ST_STORE) begin
				lane_q <= (lane_q == thi_pwm_pkg::LANE_LAST_CMP) ? 2'd0 : lane_q + 2'd1;
			end
			if (state_q == thi_pwm_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/thi_pwm_dp.sv]
// Datapath: config registers, ramp, sine lookup, shared multiplier, compare math.
module thi_pwm_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [thi_pwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [thi_pwm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [thi_pwm_pkg::FREQ_W-1:0]        target_frequency,
	input  logic                                  enable_request,
	input  logic                                  fault_reset_request,
	input  thi_pwm_pkg::cmd_t                     cmd,
	output thi_pwm_pkg::result_t                  result
);

	// Configuration
	logic [thi_pwm_pkg::PERIOD_W-1:0] period_q;
	logic [thi_pwm_pkg::STEP_W-1:0]   step_q;
	logic [thi_pwm_pkg::SCALE_W-1:0]  scale_q;
	logic [thi_pwm_pkg::GAIN_W-1:0]   gain_q;

	// Persistent state
	logic [thi_pwm_pkg::PHASE_BITS-1:0] acc_q;
	logic [thi_pwm_pkg::FREQ_W-1:0]     freq_q;
	logic                               latch_q;

	// Per-tick working registers
	logic [thi_pwm_pkg::FREQ_W-1:0]       target_q;
	logic                                 enable_q;
	logic signed [thi_pwm_pkg::PROD_W-1:0] prod_q;
	logic [thi_pwm_pkg::AMP_W-1:0]        amp_q;
	logic signed [thi_pwm_pkg::SINE_W-1:0] sine_q [4];
	logic [thi_pwm_pkg::NUM_HI_W-1:0]     num_hi_q;
	logic                                 nonpos_q;
	logic [thi_pwm_pkg::LO_PROD_W-1:0]    prod_lo_q;
	logic [thi_pwm_pkg::YQ_W-1:0]         y_q;
	logic                                 clamp_q;
	logic [thi_pwm_pkg::CMP_W-1:0]        cmp_q [3];
	thi_pwm_pkg::result_t                 result_q;

	// Combinational
	logic signed [thi_pwm_pkg::MUL_A_W-1:0] mul_a;
	logic signed [thi_pwm_pkg::MUL_B_W-1:0] mul_b;
	logic signed [thi_pwm_pkg::PROD_W-1:0]  mul_p;
	logic [thi_pwm_pkg::FREQ_W:0]           ramp_sum;
	logic [thi_pwm_pkg::FREQ_W-1:0]         ramp_diff;
	logic [thi_pwm_pkg::FREQ_W-1:0]         freq_nx;
	logic [thi_pwm_pkg::PHASE_BITS-1:0]     phase_sel;
	logic signed [thi_pwm_pkg::W6_W-1:0]    s1_x;
	logic signed [thi_pwm_pkg::W6_W-1:0]    w6;
	logic signed [thi_pwm_pkg::PROD_W-1:0]  num;
	logic [thi_pwm_pkg::P_W-1:0]            p_full;
	logic [thi_pwm_pkg::Y_W-1:0]            y_full;
	logic [thi_pwm_pkg::Y_W-1:0]            y_limit;

	assign result = result_q;

	// Ramp one step toward the target, landing exactly on it
	always_comb begin
		ramp_sum  = {1'b0, freq_q} + (thi_pwm_pkg::FREQ_W + 1)'(step_q);
		ramp_diff = freq_q - target_q;
		freq_nx   = freq_q;
		priority if (target_q > freq_q) begin
			freq_nx = (ramp_sum > {1'b0, target_q}) ? target_q
				: ramp_sum[thi_pwm_pkg::FREQ_W-1:0];
		end else if (target_q < freq_q) begin
			freq_nx = (thi_pwm_pkg::FREQ_W'(step_q) >= ramp_diff) ? target_q
				: freq_q - thi_pwm_pkg::FREQ_W'(step_q);
		end
	end

	// Phase per lane: A, B (+120), C (-120), third harmonic
	always_comb begin
		unique case (cmd.lane)
			2'd0:    phase_sel = acc_q;
			2'd1:    phase_sel = acc_q + thi_pwm_pkg::PHASE_OFFSET;
			2'd2:    phase_sel = acc_q - thi_pwm_pkg::PHASE_OFFSET;
			default: phase_sel = acc_q + {acc_q[thi_pwm_pkg::PHASE_BITS-2:0], 1'b0};
		endcase
	end

	assign s1_x = thi_pwm_pkg::W6_W'(sine_q[cmd.lane]);
	assign w6   = (s1_x <<< 2) + (s1_x <<< 1) + thi_pwm_pkg::W6_W'(sine_q[thi_pwm_pkg::LANE_THIRD]);
	assign num  = thi_pwm_pkg::NUM_BIAS - prod_q;

	// period*num = high partial product << 22 + low partial product; /(3*2^34)
	assign p_full  = {prod_q[thi_pwm_pkg::LO_PROD_W-1:0], thi_pwm_pkg::NUM_SPLIT'(0)}
		+ thi_pwm_pkg::P_W'(prod_lo_q);
	assign y_full  = p_full[thi_pwm_pkg::P_W-1 -: thi_pwm_pkg::Y_W];
	assign y_limit = thi_pwm_pkg::Y_W'({period_q, 1'b0}) + thi_pwm_pkg::Y_W'(period_q)
		+ thi_pwm_pkg::Y_W'(3);

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			thi_pwm_pkg::OP_AMP: begin
				mul_a = $signed(thi_pwm_pkg::MUL_A_W'(freq_q));
				mul_b = $signed(thi_pwm_pkg::MUL_B_W'(gain_q));
			end
			thi_pwm_pkg::OP_WEIGHT: begin
				mul_a = $signed(thi_pwm_pkg::MUL_A_W'(amp_q));
				mul_b = thi_pwm_pkg::MUL_B_W'(w6);
			end
			thi_pwm_pkg::OP_SPLIT: begin
				mul_a = $signed(thi_pwm_pkg::MUL_A_W'(period_q));
				mul_b = $signed(thi_pwm_pkg::MUL_B_W'(num[thi_pwm_pkg::NUM_SPLIT-1:0]));
			end
			thi_pwm_pkg::OP_HIGH: begin
				mul_a = $signed(thi_pwm_pkg::MUL_A_W'(period_q));
				mul_b = $signed(thi_pwm_pkg::MUL_B_W'(num_hi_q));
			end
			thi_pwm_pkg::OP_RECIP: begin
				mul_a = $signed(thi_pwm_pkg::MUL_A_W'(y_q));
				mul_b = $signed(thi_pwm_pkg::MUL_B_W'(thi_pwm_pkg::RECIP_M));
			end
			thi_pwm_pkg::OP_INCR: begin
				mul_a = $signed(thi_pwm_pkg::MUL_A_W'(freq_q));
				mul_b = $signed(thi_pwm_pkg::MUL_B_W'(scale_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = thi_pwm_pkg::PROD_W'(mul_a) * thi_pwm_pkg::PROD_W'(mul_b);

	// Config, state and control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= thi_pwm_pkg::PERIOD_RST;
			step_q   <= thi_pwm_pkg::STEP_RST;
			scale_q  <= thi_pwm_pkg::SCALE_RST;
			gain_q   <= thi_pwm_pkg::GAIN_RST;
			acc_q    <= '0;
			freq_q   <= '0;
			latch_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (thi_pwm_pkg::cfg_reg_t'(cfg_index))
					thi_pwm_pkg::REG_PWM_PERIOD:
						period_q <= cfg_data[thi_pwm_pkg::PERIOD_W-1:0];
					thi_pwm_pkg::REG_RAMP_STEP:
						step_q <= cfg_data[thi_pwm_pkg::STEP_W-1:0];
					thi_pwm_pkg::REG_PHASE_SCALE:
						scale_q <= cfg_data[thi_pwm_pkg::SCALE_W-1:0];
					thi_pwm_pkg::REG_AMPLITUDE_GAIN:
						gain_q <= cfg_data[thi_pwm_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.op == thi_pwm_pkg::OP_LOAD) latch_q <= latch_q | fault_reset_request;
			if (cmd.op == thi_pwm_pkg::OP_AMP)  freq_q  <= freq_nx;
			if (cmd.op == thi_pwm_pkg::OP_ADV) begin
				acc_q <= acc_q + prod_q[thi_pwm_pkg::INC_SHIFT +: thi_pwm_pkg::PHASE_BITS];
			end
		end
	end

	// Working payload registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			thi_pwm_pkg::OP_LOAD: begin
				target_q <= target_frequency;
				enable_q <= enable_request;
			end
			thi_pwm_pkg::OP_SINE: begin
				amp_q <= prod_q[thi_pwm_pkg::AMP_SHIFT +: thi_pwm_pkg::AMP_W];
				sine_q[cmd.lane] <= thi_pwm_pkg::sine_of(phase_sel);
			end
			thi_pwm_pkg::OP_SPLIT: begin
				nonpos_q <= !(num > 0);
				num_hi_q <= num[thi_pwm_pkg::NUM_SPLIT +: thi_pwm_pkg::NUM_HI_W];
			end
			thi_pwm_pkg::OP_HIGH: begin
				prod_lo_q <= prod_q[thi_pwm_pkg::LO_PROD_W-1:0];
			end
			thi_pwm_pkg::OP_QUOT: begin
				clamp_q <= (y_full >= y_limit);
				y_q     <= y_full[thi_pwm_pkg::YQ_W-1:0];
			end
			thi_pwm_pkg::OP_STORE: begin
				// over-modulation saturates at either rail
				if (nonpos_q)     cmp_q[cmd.lane] <= '0;
				else if (clamp_q) cmp_q[cmd.lane] <= period_q;
				else cmp_q[cmd.lane] <= prod_q[thi_pwm_pkg::RECIP_SHIFT +: thi_pwm_pkg::CMP_W];
			end
			thi_pwm_pkg::OP_DONE: begin
				result_q.compare_a           <= cmp_q[0];
				result_q.compare_b           <= cmp_q[1];
				result_q.compare_c           <= cmp_q[2];
				result_q.enable_pin          <= enable_q;
				result_q.enable_inverted_pin <= !enable_q;
				result_q.fault_reset_pin     <= latch_q;
				result_q.present_frequency   <= freq_q;
			end
			default: ;
		endcase
		unique case (cmd.op)
			thi_pwm_pkg::OP_AMP, thi_pwm_pkg::OP_WEIGHT, thi_pwm_pkg::OP_SPLIT,
			thi_pwm_pkg::OP_HIGH, thi_pwm_pkg::OP_RECIP, thi_pwm_pkg::OP_INCR:
				prod_q <= mul_p;
			default: ;
		endcase
	end

endmodule

[rtl/three_phase_thi_pwm_generator.sv]
// Top level of the three-phase sine PWM generator with third-harmonic injection.
//
//  port     | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  tick     | in  | valid/ready        | target_frequency, enable/fault_reset request
//  result   | out | valid/ready        | compare_a/b/c, pins, present_frequency
//  cfg_*    | in  | cfg_we, no backoff | cfg_index selects register, cfg_data value
//
//  A tick is accepted in idle and passes through amplitude, four sine lookups, six
//  steps per phase (four of them on the shared 26x25 multiplier), phase increment,
//  advance and result load before its result is valid.
//  The tick port is ready only while the sequencer is idle; a result left untaken
//  holds the sequencer in its last state until the result register frees up.
//  arst_n clears the phase, frequency and fault latch and loads register defaults.
module three_phase_thi_pwm_generator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [thi_pwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [thi_pwm_pkg::CFG_DATA_W-1:0]    cfg_data,
	thi_pwm_tick_if.sink                          tick,
	thi_pwm_result_if.source                      result
);

	thi_pwm_pkg::cmd_t    cmd;
	thi_pwm_pkg::result_t res;

	// Sequencer: owns both handshakes and the step order
	thi_pwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// Arithmetic, state and the result register
	thi_pwm_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.target_frequency    (tick.target_frequency),
		.enable_request      (tick.enable_request),
		.fault_reset_request (tick.fault_reset_request),
		.cmd                 (cmd),
		.result              (res)
	);

	assign result.compare_a           = res.compare_a;
	assign result.compare_b           = res.compare_b;
	assign result.compare_c           = res.compare_c;
	assign result.enable_pin          = res.enable_pin;
	assign result.enable_inverted_pin = res.enable_inverted_pin;
	assign result.fault_reset_pin     = res.fault_reset_pin;
	assign result.present_frequency   = res.present_frequency;

endmodule

[sim/three_phase_thi_pwm_generator_tb.sv]
// Self-checking testbench for the three-phase third-harmonic PWM generator.
module three_phase_thi_pwm_generator_tb;

	// Phase bit math: top 10 bits index the sine, quarter table has 257 entries
	localparam int                    QTR_LEN      = 256;
	localparam logic [31:0]           THIRD_TURN   = 32'd1431655765;
	localparam longint unsigned       TWO_PI_Q30   = 64'd6746518852;
	localparam longint unsigned       ONE_Q30      = 64'd1 << 30;
	localparam longint unsigned       CMP_DIVISOR  = 64'd12 << 32;
	localparam int                    LATENCY      = 27;
	localparam int                    WATCHDOG_MAX = 2000;
	localparam int                    HOLDOFF_LEN  = 300;
	localparam int                    SEGMENTS     = 8;
	localparam int                    SEG_TICKS    = 105;
	localparam int                    PRINT_CAP    = 100;

	typedef struct packed {
		logic [23:0] target;
		logic        enable;
		logic        fault_reset;
	} tick_req_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	thi_pwm_tick_if   tick_ch ();
	thi_pwm_result_if res_ch ();

	three_phase_thi_pwm_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick_ch),
		.result    (res_ch)
	);

	always #5 clk = ~clk;

	// Shadow of the block: registers and state
	logic [15:0] period_cfg;
	logic [15:0] step_cfg;
	logic [23:0] scale_cfg;
	logic [23:0] gain_cfg;
	logic [31:0] phase_acc;
	logic [23:0] out_freq;
	logic        fault_latch;
	longint      sine_quarter [0:QTR_LEN];

	// Requests waiting for the driver, and compare results still owed by the block
	tick_req_t                 tick_backlog [$];
	thi_pwm_pkg::result_t      owed_results [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int holdoff_req    = 0;
	int holdoff_left   = 0;
	int ticks_queued   = 0;
	int ticks_taken    = 0;
	int results_seen   = 0;
	int mismatch_count = 0;
	int reg_writes     = 0;
	int clamp_hits     = 0;
	int quiet_cycles   = 0;
	logic tick_hs      = 1'b0;

	// Signed Q16 sine of a 32-bit phase; quadrants folded onto the quarter table
	function automatic longint phase_sine(logic [31:0] ph);
		logic [9:0] idx;
		longint     mag;
		idx = ph[31:22];
		mag = idx[8] ? sine_quarter[QTR_LEN - idx[7:0]] : sine_quarter[idx[7:0]];
		return idx[9] ? -mag : mag;
	endfunction

	// period * (6 - A*(6 sin1 + sin3)) / 12, held to 0..period
	function automatic logic [15:0] compare_value(longint unsigned amp, longint s1, longint s3);
		longint          w6;
		longint          num;
		longint unsigned c;
		w6  = 6 * s1 + s3;
		num = (longint'(6) <<< 32) - longint'(amp) * w6;
		if (num <= 0) begin
			clamp_hits++;
			return 16'd0;
		end
		c = (longint'(period_cfg) * longint'(num)) / CMP_DIVISOR;
		if (c > period_cfg) begin
			clamp_hits++;
			return period_cfg;
		end
		return c[15:0];
	endfunction

	// One PWM tick: amplitude from the old frequency, ramp, compares from the old phase,
	// then the phase moves by the increment of the new frequency.
	function automatic thi_pwm_pkg::result_t predict_tick(tick_req_t rq);
		thi_pwm_pkg::result_t r;
		longint unsigned      amp;
		longint unsigned      sum;
		longint               s3;
		logic [31:0]          th;
		th = phase_acc;
		fault_latch = fault_latch | rq.fault_reset;
		amp = (longint'(out_freq) * longint'(gain_cfg)) >> 23;
		if (rq.target > out_freq) begin
			sum = longint'(out_freq) + longint'(step_cfg);
			out_freq = (sum > rq.target) ? rq.target : sum[23:0];
		end else if (rq.target < out_freq) begin
			if (step_cfg >= out_freq - rq.target)
				out_freq = rq.target;
			else
				out_freq = out_freq - step_cfg;
		end
		s3 = phase_sine(th * 32'd3);
		r.compare_a           = compare_value(amp, phase_sine(th), s3);
		r.compare_b           = compare_value(amp, phase_sine(th + THIRD_TURN), s3);
		r.compare_c           = compare_value(amp, phase_sine(th - THIRD_TURN), s3);
		r.enable_pin          = rq.enable;
		r.enable_inverted_pin = ~rq.enable;
		r.fault_reset_pin     = fault_latch;
		r.present_frequency   = out_freq;
		phase_acc = th + 32'((longint'(out_freq) * longint'(scale_cfg)) >> 16);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, longint unsigned got, longint unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s of result %0d: got %0d, want %0d",
				name, results_seen, got, want));
	endtask

	task automatic queue_tick(logic [23:0] tf, logic en, logic fr);
		tick_req_t rq;
		rq.target      = tf;
		rq.enable      = en;
		rq.fault_reset = fr;
		tick_backlog.push_back(rq);
		ticks_queued++;
	endtask

	// Register write on the plain port; shadow copy takes the masked value
	task automatic write_reg(thi_pwm_pkg::cfg_reg_t idx, logic [23:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			thi_pwm_pkg::REG_PWM_PERIOD:     period_cfg = val[15:0];
			thi_pwm_pkg::REG_RAMP_STEP:      step_cfg   = val[15:0];
			thi_pwm_pkg::REG_PHASE_SCALE:    scale_cfg  = val;
			thi_pwm_pkg::REG_AMPLITUDE_GAIN: gain_cfg   = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sender pause: every queued request taken and every result back
	task automatic drain();
		while (ticks_taken != ticks_queued || owed_results.size() != 0)
			@(negedge clk);
	endtask

	// Driver: a new request goes up at the falling edge once the old one was taken
	always @(negedge clk) begin : tick_driver
		tick_req_t nxt;
		if (!arst_n) begin
			tick_ch.valid <= 1'b0;
		end else if (!tick_ch.valid || tick_hs) begin
			if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = tick_backlog.pop_front();
				tick_ch.valid               <= 1'b1;
				tick_ch.target_frequency    <= nxt.target;
				tick_ch.enable_request      <= nxt.enable;
				tick_ch.fault_reset_request <= nxt.fault_reset;
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off counted here when asked for
	always @(negedge clk) begin : result_sink
		if (holdoff_req > 0) begin
			holdoff_left = holdoff_req;
			holdoff_req  = 0;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predict on each accepted request, check each accepted result, watchdog last
	always @(posedge clk) begin : monitor
		thi_pwm_pkg::result_t want;
		tick_req_t            rq;
		logic                 moved;
		if (arst_n) begin
			moved   = 1'b0;
			tick_hs <= tick_ch.valid && tick_ch.ready;
			if (tick_ch.valid && tick_ch.ready) begin
				rq.target      = tick_ch.target_frequency;
				rq.enable      = tick_ch.enable_request;
				rq.fault_reset = tick_ch.fault_reset_request;
				owed_results.push_back(predict_tick(rq));
				ticks_taken++;
				moved = 1'b1;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (owed_results.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = owed_results.pop_front();
					check_field("compare_a", res_ch.compare_a, want.compare_a);
					check_field("compare_b", res_ch.compare_b, want.compare_b);
					check_field("compare_c", res_ch.compare_c, want.compare_c);
					check_field("enable_pin", res_ch.enable_pin, want.enable_pin);
					check_field("enable_inverted_pin", res_ch.enable_inverted_pin,
						want.enable_inverted_pin);
					check_field("fault_reset_pin", res_ch.fault_reset_pin,
						want.fault_reset_pin);
					check_field("present_frequency", res_ch.present_frequency,
						want.present_frequency);
				end
				results_seen++;
				moved = 1'b1;
			end
			if (moved || (ticks_taken == ticks_queued && owed_results.size() == 0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("watchdog: no request moved for %0d cycles", quiet_cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin : stimulus
		longint unsigned x, x2, t, span;
		int              divs [5];
		int              seg, k, pick;
		logic [15:0]     per_v, step_v;
		logic [23:0]     scale_v, gain_v, tgt, prev_tgt;

		// Inputs known from time zero
		arst_n                      = 1'b0;
		cfg_we                      = 1'b0;
		cfg_index                   = '0;
		cfg_data                    = '0;
		tick_ch.valid               = 1'b0;
		tick_ch.target_frequency    = '0;
		tick_ch.enable_request      = 1'b0;
		tick_ch.fault_reset_request = 1'b0;
		res_ch.ready                = 1'b0;

		// Quarter-wave sine, Taylor series in Q30 rounded to Q16
		divs = '{110, 72, 42, 20, 6};
		for (int q = 0; q <= QTR_LEN; q++) begin
			x  = (longint'(q) * TWO_PI_Q30) >> 10;
			x2 = (x * x) >> 30;
			t  = ONE_Q30;
			foreach (divs[i])
				t = ONE_Q30 - (((x2 * t) >> 30) / divs[i]);
			sine_quarter[q] = longint'((((x * t) >> 30) + 64'd8192) >> 14);
		end

		// Post-reset shadow state
		period_cfg  = thi_pwm_pkg::PERIOD_RST;
		step_cfg    = thi_pwm_pkg::STEP_RST;
		scale_cfg   = thi_pwm_pkg::SCALE_RST;
		gain_cfg    = thi_pwm_pkg::GAIN_RST;
		phase_acc   = '0;
		out_freq    = '0;
		fault_latch = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset defaults: ramp landing on a small target, full-scale target,
		// enable both ways, fault request then the latch holding on its own
		queue_tick(24'd0, 1'b0, 1'b0);
		queue_tick(24'd0, 1'b1, 1'b0);
		queue_tick(24'd8, 1'b1, 1'b0);
		queue_tick(24'hFFFFFF, 1'b1, 1'b0);
		queue_tick(24'hFFFFFF, 1'b0, 1'b1);
		queue_tick(24'hFFFFFF, 1'b1, 1'b0);
		queue_tick(24'd0, 1'b0, 1'b0);
		queue_tick(24'd20, 1'b1, 1'b0);
		drain();

		// Directed, every register at its top, junk above the 16-bit fields;
		// full gain drives the modulator deep into saturation at both rails
		write_reg(thi_pwm_pkg::REG_PWM_PERIOD, 24'hA5FFFF);
		write_reg(thi_pwm_pkg::REG_RAMP_STEP, 24'h5AFFFF);
		write_reg(thi_pwm_pkg::REG_PHASE_SCALE, 24'hFFFFFF);
		write_reg(thi_pwm_pkg::REG_AMPLITUDE_GAIN, 24'hFFFFFF);
		for (k = 0; k < 5; k++)
			queue_tick(24'hFFFFFF, k[0], 1'b0);
		queue_tick(24'd0, 1'b1, 1'b0);
		queue_tick(24'd5, 1'b1, 1'b0);
		queue_tick(24'd70000, 1'b0, 1'b0);
		drain();

		// Directed, zero period and zero ramp: compares all zero, frequency frozen
		write_reg(thi_pwm_pkg::REG_PWM_PERIOD, 24'h000000);
		write_reg(thi_pwm_pkg::REG_RAMP_STEP, 24'h000000);
		queue_tick(24'hFFFFFF, 1'b1, 1'b0);
		queue_tick(24'd0, 1'b0, 1'b0);
		queue_tick(24'h800000, 1'b1, 1'b0);
		drain();

		// Directed, zero gain and zero phase scale: flat half-period compares
		write_reg(thi_pwm_pkg::REG_PWM_PERIOD, 24'h000001);
		write_reg(thi_pwm_pkg::REG_PHASE_SCALE, 24'h000000);
		write_reg(thi_pwm_pkg::REG_AMPLITUDE_GAIN, 24'h000000);
		queue_tick(24'd1, 1'b1, 1'b0);
		queue_tick(24'd2, 1'b0, 1'b0);
		drain();
		write_reg(thi_pwm_pkg::REG_PWM_PERIOD, 24'h0003E8);
		write_reg(thi_pwm_pkg::REG_RAMP_STEP, 24'h000100);
		queue_tick(24'd3, 1'b1, 1'b0);
		queue_tick(24'd600, 1'b0, 1'b0);
		drain();

		// Random segments, each with its own register setting and idling mode
		prev_tgt = '0;
		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase

			pick = $urandom_range(3);
			if (pick == 0)
				per_v = $urandom_range(1) ? 16'hFFFF : 16'd1;
			else
				per_v = 16'($urandom_range(1, 65535));
			pick = $urandom_range(5);
			case (pick)
				0: step_v = 16'd0;
				1: step_v = 16'hFFFF;
				2, 3: step_v = 16'($urandom_range(1, 255));
				default: step_v = 16'($urandom_range(65535));
			endcase
			scale_v = ($urandom_range(3) == 0) ? 24'hFFFFFF : 24'($urandom);
			pick = $urandom_range(3);
			case (pick)
				0: gain_v = 24'($urandom);
				3: gain_v = thi_pwm_pkg::GAIN_RST;
				default: gain_v = 24'($urandom_range(0, 1 << 18));
			endcase
			write_reg(thi_pwm_pkg::REG_PWM_PERIOD, {8'($urandom), per_v});
			write_reg(thi_pwm_pkg::REG_RAMP_STEP, {8'($urandom), step_v});
			write_reg(thi_pwm_pkg::REG_PHASE_SCALE, scale_v);
			write_reg(thi_pwm_pkg::REG_AMPLITUDE_GAIN, gain_v);

			// Targets mostly within a few ramp steps so the frequency lands on them
			span = (longint'(step_v) + 1) * $urandom_range(2, 16);
			if (span > 64'hFFFFFF)
				span = 64'hFFFFFF;
			for (k = 0; k < SEG_TICKS; k++) begin
				pick = $urandom_range(99);
				if (pick < 70)
					tgt = 24'($urandom_range(0, int'(span)));
				else if (pick < 85)
					tgt = 24'($urandom);
				else
					tgt = prev_tgt;
				prev_tgt = tgt;
				queue_tick(tgt, 1'($urandom), ($urandom_range(15) == 0));
				// one sender pause in the middle of a segment
				if (seg == 2 && k == SEG_TICKS / 2)
					drain();
			end
			// Receiver holds off while the sender keeps offering, so input stalls
			if (seg == 0 || seg == 5)
				holdoff_req = HOLDOFF_LEN;
			drain();
		end

		repeat (LATENCY + 13) @(negedge clk);

		$display("checked %0d results from %0d requests over %0d register writes",
			results_seen, ticks_taken, reg_writes);
		$display("compare values held at a rail: %0d, mismatches: %0d",
			clamp_hits, mismatch_count);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
